[hw/rtl/spq_pkg.sv]
`default_nettype none

package spq_pkg;

  // Field widths of the item types.
  localparam int unsigned PRIO_W = 16;
  localparam int unsigned INFO_W = 8;
  localparam int unsigned CNT_W  = 6;
  localparam int unsigned CAP_W  = 6;

  // Requested operation of an input item.
  typedef enum logic [0:0] {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_e;

  // Outcome reported with every result item.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Sequencer states of the queue controller.
  typedef enum logic [2:0] {
    S_IDLE,
    S_CMP,
    S_PUT,
    S_RESP,
    S_DEQ
  } state_e;

  typedef struct packed {
    action_e           action;
    logic [PRIO_W-1:0] new_prio;
    logic [INFO_W-1:0] new_info;
  } in_t;

  typedef struct packed {
    logic [PRIO_W-1:0] head_prio;
    logic [INFO_W-1:0] head_info;
    status_e           status;
    logic [CNT_W-1:0]  count;
  } out_t;

endpackage

`default_nettype wire

[hw/rtl/sorted_insert_priority_queue.sv]
// Bounded priority queue of (priority, character) entries kept sorted in a
// circular RAM of DEPTH slots, of which the capacity register uses the first
// capacity slots (a write of 0 acts as 1, a value above DEPTH acts as DEPTH,
// and any write empties the queue). An enqueue is placed behind the tail and
// moved toward the head past every entry of strictly greater priority, so
// equal priorities leave in arrival order; a dequeue returns the head entry.
// Every accepted item gives exactly one result item with a status and the
// entry count after the step. A refused item or an enqueue into an empty
// queue is answered straight from idle; a dequeue reads the head, then
// answers; any other enqueue runs the insertion walk, then a put step when
// the new entry ends up at the head, then the response step. The walk makes
// at most as many compares as there are entries held, one a cycle through
// the single RAM read port and one priority comparator. The block accepts
// no new item until the current one has finished and the output register
// is free.
`default_nettype none

module sorted_insert_priority_queue #(
  parameter int unsigned DEPTH     = 32,
  parameter int unsigned PRIO_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire spq_pkg::in_t                        in_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output spq_pkg::out_t                            out_data_o,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [spq_pkg::CAP_W-1:0]           cfg_data_i
);

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned SW = (PRIO_BITS < spq_pkg::PRIO_W) ? PRIO_BITS : spq_pkg::PRIO_W;
  localparam int unsigned EW = SW + spq_pkg::INFO_W;
  localparam int unsigned MW = ((IW > spq_pkg::CAP_W) ? IW : spq_pkg::CAP_W) + 1;
  localparam logic [spq_pkg::CAP_W-1:0] CapReset =
    spq_pkg::CAP_W'((DEPTH < 32) ? DEPTH : 32);

  // Circular index helpers over the active capacity.
  function automatic logic [IW-1:0] wrap_next(logic [IW-1:0] idx,
                                              logic [spq_pkg::CAP_W-1:0] cap);
    logic [MW-1:0] nxt;
    nxt = MW'(idx) + MW'(1);
    return (nxt >= MW'(cap)) ? '0 : IW'(nxt);
  endfunction

  function automatic logic [IW-1:0] wrap_prev(logic [IW-1:0] idx,
                                              logic [spq_pkg::CAP_W-1:0] cap);
    logic [spq_pkg::CAP_W-1:0] last;
    last = cap - spq_pkg::CAP_W'(1);
    return (idx == '0) ? IW'(last) : (idx - IW'(1));
  endfunction

  spq_pkg::state_e state_q, state_d;
  logic [IW-1:0] head_q, head_d;
  logic [IW-1:0] tail_q, tail_d;
  logic [IW-1:0] hole_q, hole_d;
  logic [IW-1:0] rptr_q, rptr_d;
  logic [spq_pkg::CNT_W-1:0] count_q, count_d;
  logic [spq_pkg::CAP_W-1:0] cap_q, cap_d;
  logic [EW-1:0] ins_q, ins_d;
  logic out_valid_q, out_valid_d;
  spq_pkg::out_t out_data_q, out_data_d;

  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic          ram_re;
  logic [IW-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic          out_free;
  logic [EW-1:0] new_entry;
  logic [IW-1:0] tail_next;
  logic [IW-1:0] rptr_prev;
  logic [spq_pkg::CAP_W-1:0] cap_clamped;

  spq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign out_free    = !out_valid_q || out_ready_i;
  assign new_entry   = {in_data_i.new_prio[SW-1:0], in_data_i.new_info};
  assign tail_next   = wrap_next(tail_q, cap_q);
  assign rptr_prev   = wrap_prev(rptr_q, cap_q);
  assign cfg_ready_o = (state_q == spq_pkg::S_IDLE);
  assign in_ready_o  = (state_q == spq_pkg::S_IDLE) && !cfg_valid_i && out_free;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Clamp a written capacity into the range the store supports.
  always_comb begin
    if (cfg_data_i == '0) begin
      cap_clamped = spq_pkg::CAP_W'(1);
    end else if (32'(cfg_data_i) > 32'(DEPTH)) begin
      cap_clamped = spq_pkg::CAP_W'(DEPTH);
    end else begin
      cap_clamped = cfg_data_i;
    end
  end

  // Sequencer: next state, queue pointers, RAM controls and result item.
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    hole_d      = hole_q;
    rptr_d      = rptr_q;
    count_d     = count_q;
    cap_d       = cap_q;
    ins_d       = ins_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = hole_q;
    ram_wdata   = ins_q;
    ram_re      = 1'b0;
    ram_raddr   = rptr_q;

    case (state_q)
      spq_pkg::S_IDLE: begin
        if (cfg_valid_i) begin
          // A capacity write empties the queue.
          cap_d   = cap_clamped;
          head_d  = '0;
          tail_d  = '0;
          count_d = '0;
        end else if (in_valid_i && out_free) begin
          out_data_d.head_prio = '0;
          out_data_d.head_info = '0;
          out_data_d.status    = spq_pkg::ST_DONE;
          out_data_d.count     = count_q;
          if (in_data_i.action == spq_pkg::ACT_ENQ) begin
            if (count_q >= cap_q) begin
              out_data_d.status = spq_pkg::ST_FULL;
              out_valid_d       = 1'b1;
            end else if (count_q == '0) begin
              // First entry goes straight to slot zero.
              ram_we           = 1'b1;
              ram_waddr        = '0;
              ram_wdata        = new_entry;
              head_d           = '0;
              tail_d           = '0;
              count_d          = spq_pkg::CNT_W'(1);
              out_data_d.count = spq_pkg::CNT_W'(1);
              out_valid_d      = 1'b1;
            end else begin
              // Open a hole behind the tail and start reading the old tail.
              tail_d    = tail_next;
              hole_d    = tail_next;
              rptr_d    = tail_q;
              ram_re    = 1'b1;
              ram_raddr = tail_q;
              ins_d     = new_entry;
              count_d   = count_q + spq_pkg::CNT_W'(1);
              state_d   = spq_pkg::S_CMP;
            end
          end else begin
            if (count_q == '0) begin
              out_data_d.status = spq_pkg::ST_EMPTY;
              out_valid_d       = 1'b1;
            end else begin
              ram_re    = 1'b1;
              ram_raddr = head_q;
              if (count_q == spq_pkg::CNT_W'(1)) begin
                head_d = '0;
                tail_d = '0;
              end else begin
                head_d = wrap_next(head_q, cap_q);
              end
              count_d = count_q - spq_pkg::CNT_W'(1);
              state_d = spq_pkg::S_DEQ;
            end
          end
        end
      end

      spq_pkg::S_CMP: begin
        // Shift a larger entry into the hole, or drop the new entry there.
        if (ins_q[EW-1:spq_pkg::INFO_W] < ram_rdata[EW-1:spq_pkg::INFO_W]) begin
          ram_we    = 1'b1;
          ram_waddr = hole_q;
          ram_wdata = ram_rdata;
          hole_d    = rptr_q;
          if (rptr_q == head_q) begin
            state_d = spq_pkg::S_PUT;
          end else begin
            rptr_d    = rptr_prev;
            ram_re    = 1'b1;
            ram_raddr = rptr_prev;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = hole_q;
          ram_wdata = ins_q;
          state_d   = spq_pkg::S_RESP;
        end
      end

      spq_pkg::S_PUT: begin
        // The new entry becomes the head.
        ram_we    = 1'b1;
        ram_waddr = hole_q;
        ram_wdata = ins_q;
        state_d   = spq_pkg::S_RESP;
      end

      spq_pkg::S_RESP: begin
        if (out_free) begin
          out_data_d.head_prio = '0;
          out_data_d.head_info = '0;
          out_data_d.status    = spq_pkg::ST_DONE;
          out_data_d.count     = count_q;
          out_valid_d          = 1'b1;
          state_d              = spq_pkg::S_IDLE;
        end
      end

      spq_pkg::S_DEQ: begin
        // Read data holds until the output register is free.
        if (out_free) begin
          out_data_d.head_prio = spq_pkg::PRIO_W'(ram_rdata[EW-1:spq_pkg::INFO_W]);
          out_data_d.head_info = ram_rdata[spq_pkg::INFO_W-1:0];
          out_data_d.status    = spq_pkg::ST_DONE;
          out_data_d.count     = count_q;
          out_valid_d          = 1'b1;
          state_d              = spq_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= spq_pkg::S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      cap_q       <= cap_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk_i) begin
    hole_q     <= hole_d;
    rptr_q     <= rptr_d;
    ins_q      <= ins_d;
    out_data_q <= out_data_d;
  end

  // The entry count never exceeds the active capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= cap_q)
    else $error("entry count above capacity");

  // The head pointer stays inside the active slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni) MW'(head_q) < MW'(cap_q))
    else $error("head index outside capacity");

  // An insertion in progress works on a queue that holds entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != spq_pkg::S_IDLE && state_q != spq_pkg::S_DEQ) |-> (count_q != '0))
    else $error("busy with an empty queue");

  // While the insertion walk compares, the hole is never on the head slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == spq_pkg::S_CMP) |-> (hole_q != head_q))
    else $error("insertion walk passed the head");

  // A capacity write leaves an empty, idle queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |=> (count_q == '0) && (state_q == spq_pkg::S_IDLE))
    else $error("capacity write did not empty the queue");

endmodule

`default_nettype wire

[hw/rtl/spq_ram.sv]
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; read data holds between reads.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire
